// ===== sv/ccd_pkg.sv =====
// Shared types and constants of the color cell decoder.
// Holds the cell command passed from the parser to the pixel expander.
// No dependencies.
`default_nettype none

package ccd_pkg;

	// Palette store geometry
	localparam int PALETTE_DEPTH = 256;
	localparam int PAL_AW = $clog2(PALETTE_DEPTH);

	// Cell geometry: 4x4 pixels
	localparam int CELL_SIZE = 4;
	localparam int CELL_SHIFT = $clog2(CELL_SIZE);

	// Command queue between parser and expander
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	typedef logic [1:0] err_code_t;
	localparam err_code_t ERR_NONE = 2'd0;
	localparam err_code_t ERR_NOT_CCC = 2'd1;
	localparam err_code_t ERR_SIZE_CODE = 2'd2;

	// One queued command: a full cell, or an error report
	typedef struct packed {
		logic is_err;
		err_code_t err;
		logic [15:0] bitmap;
		logic [23:0] color0;
		logic [23:0] color1;
		logic [7:0] cell_col;
		logic [7:0] cell_row;
		logic last_cell;
	} cell_cmd_t;

	// Image width for a size code
	function automatic logic [9:0] size_width(input logic [2:0] code);
		logic [9:0] w;
		case (code)
			3'd0: w = 10'd128;
			3'd1: w = 10'd256;
			3'd2: w = 10'd512;
			3'd3: w = 10'd768;
			3'd4: w = 10'd320;
			3'd5: w = 10'd640;
			3'd6: w = 10'd640;
			default: w = 10'd64;
		endcase
		return w;
	endfunction

	// Image height for a size code
	function automatic logic [9:0] size_height(input logic [2:0] code);
		logic [9:0] h;
		case (code)
			3'd0: h = 10'd128;
			3'd1: h = 10'd256;
			3'd2: h = 10'd512;
			3'd3: h = 10'd768;
			3'd4: h = 10'd200;
			3'd5: h = 10'd400;
			3'd6: h = 10'd480;
			default: h = 10'd64;
		endcase
		return h;
	endfunction

endpackage

`default_nettype wire

// ===== sv/ccd_in_if.sv =====
// Byte stream channel of the color cell decoder.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface ccd_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	logic frame_start;

	modport source(output valid, output data_byte, output frame_start, input ready);
	modport sink(input valid, input data_byte, input frame_start, output ready);
endinterface

`default_nettype wire

// ===== sv/ccd_out_if.sv =====
// Pixel channel of the color cell decoder.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface ccd_out_if;
	logic valid;
	logic ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [9:0] column;
	logic [9:0] row;
	logic last_of_cell;
	logic frame_done;
	logic [1:0] error_code;

	modport source(output valid, output red, output green, output blue, output column,
		output row, output last_of_cell, output frame_done, output error_code, input ready);
	modport sink(input valid, input red, input green, input blue, input column,
		input row, input last_of_cell, input frame_done, input error_code, output ready);
endinterface

`default_nettype wire

// ===== sv/ccd_parser.sv =====
// Front end: parses the byte stream, loads the palette store and builds
// cell commands. Depends on ccd_pkg and ccd_in_if.
`default_nettype none

module ccd_parser (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_wdata,
	ccd_in_if.sink byte_stream,
	output logic cmd_valid,
	output ccd_pkg::cell_cmd_t cmd,
	input wire logic cmd_full
);

	typedef enum logic [5:0] {
		PH_TYPE    = 6'b000001,
		PH_SIZE    = 6'b000010,
		PH_COUNT   = 6'b000100,
		PH_PALETTE = 6'b001000,
		PH_CELLS   = 6'b010000,
		PH_HALT    = 6'b100000
	} phase_t;

	localparam logic [8:0] PAL_LIMIT = 9'(ccd_pkg::PALETTE_DEPTH);
	localparam logic [10:0] CELL_STEP = 11'(ccd_pkg::CELL_SIZE);

	// Parser state
	phase_t phase_q;
	logic skip_q;
	logic [9:0] width_q;
	logic [9:0] height_q;
	logic [8:0] pal_count_q;
	logic [8:0] pal_index_q;
	logic [1:0] comp_q;
	logic [1:0] cbyte_q;
	logic [7:0] bm_hi_q;
	logic [7:0] bm_lo_q;
	logic [7:0] first_q;
	logic [7:0] col_q;
	logic [7:0] row_q;

	// Palette store, one array per color lane, valid bit per entry
	logic [7:0] red_mem [ccd_pkg::PALETTE_DEPTH];
	logic [7:0] green_mem [ccd_pkg::PALETTE_DEPTH];
	logic [7:0] blue_mem [ccd_pkg::PALETTE_DEPTH];
	logic [ccd_pkg::PALETTE_DEPTH-1:0] pal_valid_q;

	// Stage 1: command waiting for palette read data and queue room
	logic valid_s1;
	logic is_err_s1;
	ccd_pkg::err_code_t err_s1;
	logic [15:0] bitmap_s1;
	logic [7:0] col_s1;
	logic [7:0] row_s1;
	logic last_s1;
	logic [7:0] r0_s1, g0_s1, b0_s1, r1_s1, g1_s1, b1_s1;
	logic v0_s1, v1_s1;

	logic fire;
	logic push;
	phase_t cur_phase;
	phase_t phase_d;
	logic is_size;
	logic emit_err;
	ccd_pkg::err_code_t err_val;
	logic pal_we;
	logic cell_done;
	logic last_cell;
	logic [8:0] pal_index_inc;
	logic [ccd_pkg::PAL_AW-1:0] wr_addr;
	logic [ccd_pkg::PAL_AW-1:0] rd_addr0;
	logic [ccd_pkg::PAL_AW-1:0] rd_addr1;
	logic in_range0, in_range1;

	// Handshake: take a byte unless a command is stuck in stage 1
	assign push = valid_s1 && !cmd_full;
	assign byte_stream.ready = !valid_s1 || !cmd_full;
	assign fire = byte_stream.valid && byte_stream.ready;

	assign cur_phase = byte_stream.frame_start ? PH_TYPE : phase_q;
	assign pal_index_inc = pal_index_q + 9'd1;
	assign last_cell = ({1'b0, col_q, 2'b00} + CELL_STEP >= {1'b0, width_q})
		&& ({1'b0, row_q, 2'b00} + CELL_STEP >= {1'b0, height_q});

	// Phase decode for the byte on the channel
	always_comb begin
		phase_d = cur_phase;
		is_size = 1'b0;
		emit_err = 1'b0;
		err_val = ccd_pkg::ERR_NONE;
		pal_we = 1'b0;
		cell_done = 1'b0;
		case (cur_phase)
			PH_TYPE: begin
				if (skip_q) begin
					is_size = 1'b1;
				end else if (byte_stream.data_byte != 8'd0) begin
					emit_err = 1'b1;
					err_val = ccd_pkg::ERR_NOT_CCC;
					phase_d = PH_HALT;
				end else begin
					phase_d = PH_SIZE;
				end
			end
			PH_SIZE: is_size = 1'b1;
			PH_COUNT: phase_d = PH_PALETTE;
			PH_PALETTE: begin
				pal_we = pal_index_q < PAL_LIMIT;
				if (comp_q >= 2'd2 && pal_index_inc >= pal_count_q) begin
					phase_d = PH_CELLS;
				end
			end
			PH_CELLS: begin
				if (cbyte_q == 2'd3) begin
					cell_done = 1'b1;
					if (last_cell) begin
						phase_d = PH_HALT;
					end
				end
			end
			default: ;
		endcase
		if (is_size) begin
			if (byte_stream.data_byte[7:3] != 5'd0) begin
				emit_err = 1'b1;
				err_val = ccd_pkg::ERR_SIZE_CODE;
				phase_d = PH_HALT;
			end else begin
				phase_d = PH_COUNT;
			end
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 1'b0;
		end else if (cfg_we) begin
			skip_q <= cfg_wdata;
		end
	end

	// Parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			width_q <= '0;
			height_q <= '0;
			pal_count_q <= '0;
			pal_index_q <= '0;
			comp_q <= '0;
			cbyte_q <= '0;
			bm_hi_q <= '0;
			bm_lo_q <= '0;
			first_q <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			if (is_size && byte_stream.data_byte[7:3] == 5'd0) begin
				width_q <= ccd_pkg::size_width(byte_stream.data_byte[2:0]);
				height_q <= ccd_pkg::size_height(byte_stream.data_byte[2:0]);
			end
			if (cur_phase == PH_COUNT) begin
				pal_count_q <= {1'b0, byte_stream.data_byte} + 9'd1;
				pal_index_q <= '0;
				comp_q <= '0;
			end
			if (cur_phase == PH_PALETTE) begin
				if (comp_q >= 2'd2) begin
					comp_q <= '0;
					pal_index_q <= pal_index_inc;
					if (pal_index_inc >= pal_count_q) begin
						cbyte_q <= '0;
						col_q <= '0;
						row_q <= '0;
					end
				end else begin
					comp_q <= comp_q + 2'd1;
				end
			end
			if (cur_phase == PH_CELLS) begin
				cbyte_q <= cbyte_q + 2'd1;
				case (cbyte_q)
					2'd0: bm_hi_q <= byte_stream.data_byte;
					2'd1: bm_lo_q <= byte_stream.data_byte;
					2'd2: first_q <= byte_stream.data_byte;
					default: begin
						// step to the next cell, wrapping at the right edge
						if ({1'b0, col_q, 2'b00} + CELL_STEP >= {1'b0, width_q}) begin
							col_q <= '0;
							row_q <= row_q + 8'd1;
						end else begin
							col_q <= col_q + 8'd1;
						end
					end
				endcase
			end
		end
	end

	// Palette writes: a lane write to a fresh entry zeroes the other lanes
	assign wr_addr = pal_index_q[ccd_pkg::PAL_AW-1:0];
	assign rd_addr0 = first_q[ccd_pkg::PAL_AW-1:0];
	assign rd_addr1 = byte_stream.data_byte[ccd_pkg::PAL_AW-1:0];
	assign in_range0 = {1'b0, first_q} < PAL_LIMIT;
	assign in_range1 = {1'b0, byte_stream.data_byte} < PAL_LIMIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_valid_q <= '0;
		end else if (fire && pal_we) begin
			pal_valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && pal_we) begin
			if (comp_q == 2'd0 || !pal_valid_q[wr_addr]) begin
				red_mem[wr_addr] <= (comp_q == 2'd0) ? byte_stream.data_byte : 8'd0;
			end
			if (comp_q == 2'd1 || !pal_valid_q[wr_addr]) begin
				green_mem[wr_addr] <= (comp_q == 2'd1) ? byte_stream.data_byte : 8'd0;
			end
			if (comp_q == 2'd2 || !pal_valid_q[wr_addr]) begin
				blue_mem[wr_addr] <= (comp_q == 2'd2) ? byte_stream.data_byte : 8'd0;
			end
		end
		// Two-port read of both cell colors on the cell's last byte
		if (fire && cell_done) begin
			r0_s1 <= red_mem[rd_addr0];
			g0_s1 <= green_mem[rd_addr0];
			b0_s1 <= blue_mem[rd_addr0];
			r1_s1 <= red_mem[rd_addr1];
			g1_s1 <= green_mem[rd_addr1];
			b1_s1 <= blue_mem[rd_addr1];
			v0_s1 <= pal_valid_q[rd_addr0] && in_range0;
			v1_s1 <= pal_valid_q[rd_addr1] && in_range1;
		end
	end

	// Stage 1 command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (fire && (emit_err || cell_done)) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (emit_err || cell_done)) begin
			is_err_s1 <= emit_err;
			err_s1 <= err_val;
			bitmap_s1 <= {bm_hi_q, bm_lo_q};
			col_s1 <= col_q;
			row_s1 <= row_q;
			last_s1 <= last_cell;
		end
	end

	// Command toward the queue; unloaded entries read black
	assign cmd_valid = valid_s1;
	always_comb begin
		cmd.is_err = is_err_s1;
		cmd.err = err_s1;
		cmd.bitmap = bitmap_s1;
		cmd.color0 = v0_s1 ? {r0_s1, g0_s1, b0_s1} : 24'd0;
		cmd.color1 = v1_s1 ? {r1_s1, g1_s1, b1_s1} : 24'd0;
		cmd.cell_col = col_s1;
		cmd.cell_row = row_s1;
		cmd.last_cell = last_s1;
	end

endmodule

`default_nettype wire

// ===== sv/ccd_queue.sv =====
// Short command queue between the parser and the pixel expander.
// Depends on ccd_pkg.
`default_nettype none

module ccd_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push_valid,
	input wire ccd_pkg::cell_cmd_t push_cmd,
	output logic full,
	output logic pop_valid,
	output ccd_pkg::cell_cmd_t pop_cmd,
	input wire logic pop
);

	ccd_pkg::cell_cmd_t entry_q [ccd_pkg::QUEUE_DEPTH];
	logic [ccd_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [ccd_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [ccd_pkg::QUEUE_AW:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = count_q == (ccd_pkg::QUEUE_AW + 1)'(ccd_pkg::QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_cmd = entry_q[rd_ptr_q];
	assign do_push = push_valid && !full;
	assign do_pop = pop && pop_valid;

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/ccd_expander.sv =====
// Back end: expands one cell command into 16 pixels, one per cycle
// unless stalled, or into one error item. Uses ccd_pkg, ccd_out_if.
`default_nettype none

module ccd_expander (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input wire ccd_pkg::cell_cmd_t cmd,
	output logic cmd_pop,
	ccd_out_if.source pixels
);

	ccd_pkg::cell_cmd_t cur_q;
	logic busy_q;
	logic [3:0] pix_q;

	// Output register
	logic out_valid_q;
	logic [7:0] red_q, green_q, blue_q;
	logic [9:0] column_q, row_q;
	logic last_q, done_q;
	ccd_pkg::err_code_t err_q;

	logic advance;
	logic final_px;
	logic load;
	logic sel_bit;
	logic [23:0] rgb;
	logic [9:0] x0, y0;

	assign advance = busy_q && (!out_valid_q || pixels.ready);
	assign final_px = cur_q.is_err || pix_q == 4'd15;
	assign load = cmd_valid && (!busy_q || (advance && final_px));
	assign cmd_pop = load;

	// Pixel of the current step; bitmap is read MSB first
	assign sel_bit = cur_q.bitmap[4'd15 - pix_q];
	assign rgb = sel_bit ? cur_q.color1 : cur_q.color0;
	assign x0 = {cur_q.cell_col, ccd_pkg::CELL_SHIFT'(0)};
	assign y0 = {cur_q.cell_row, ccd_pkg::CELL_SHIFT'(0)};

	// Command register and pixel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pix_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			pix_q <= '0;
		end else if (advance) begin
			pix_q <= pix_q + 4'd1;
			if (final_px) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= cmd;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (pixels.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (advance) begin
			if (cur_q.is_err) begin
				red_q <= '0;
				green_q <= '0;
				blue_q <= '0;
				column_q <= '0;
				row_q <= '0;
				last_q <= 1'b1;
				done_q <= 1'b0;
				err_q <= cur_q.err;
			end else begin
				red_q <= rgb[23:16];
				green_q <= rgb[15:8];
				blue_q <= rgb[7:0];
				column_q <= x0 + {8'd0, pix_q[1:0]};
				row_q <= y0 + {8'd0, pix_q[3:2]};
				last_q <= final_px;
				done_q <= final_px && cur_q.last_cell;
				err_q <= ccd_pkg::ERR_NONE;
			end
		end
	end

	assign pixels.valid = out_valid_q;
	assign pixels.red = red_q;
	assign pixels.green = green_q;
	assign pixels.blue = blue_q;
	assign pixels.column = column_q;
	assign pixels.row = row_q;
	assign pixels.last_of_cell = last_q;
	assign pixels.frame_done = done_q;
	assign pixels.error_code = err_q;

endmodule

`default_nettype wire

// ===== sv/color_cell_decoder.sv =====
// Color cell (4x4) image decoder, top level.
// Depends on ccd_pkg, ccd_in_if, ccd_out_if, ccd_parser, ccd_queue, ccd_expander.
//
// Usage: the compressed file enters one byte per item on byte_stream
// (data_byte, frame_start); frame_start on a byte restarts the parser.
// Decoded pixels leave on the pixels channel, 16 per cell in cell order,
// each with its column and row; a bad type byte or size code yields one
// error item and the parser ignores bytes until the next frame_start.
// cfg_we/cfg_wdata write skip_type_byte; the user writes it only while the
// block is idle, which the block itself does not enforce. Header and palette
// bytes are taken one per cycle unless a command waits in stage 1 for queue
// room. The expander emits one pixel per cycle while the receiver takes them;
// a four-entry command queue lets the parser run ahead by a few cells. A
// cell's first pixel passes the stage-1 register (two-port palette read),
// a queue entry, the expander command register and the output register.
// Reset clears the parser, the queue and all palette valid bits, so
// unloaded palette entries read black. When the receiver stalls, the
// output register holds its item, the queue fills and byte_stream.ready
// drops; nothing is lost.
`default_nettype none

module color_cell_decoder (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_wdata,
	ccd_in_if.sink byte_stream,
	ccd_out_if.source pixels
);

	logic cmd_valid;
	ccd_pkg::cell_cmd_t cmd;
	logic cmd_full;
	logic q_valid;
	ccd_pkg::cell_cmd_t q_cmd;
	logic q_pop;

	// Front: parsing and palette
	ccd_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.byte_stream(byte_stream),
		.cmd_valid(cmd_valid),
		.cmd(cmd),
		.cmd_full(cmd_full)
	);

	// Decoupling queue
	ccd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(cmd_valid),
		.push_cmd(cmd),
		.full(cmd_full),
		.pop_valid(q_valid),
		.pop_cmd(q_cmd),
		.pop(q_pop)
	);

	// Back: pixel expansion
	ccd_expander u_expander (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(q_valid),
		.cmd(q_cmd),
		.cmd_pop(q_pop),
		.pixels(pixels)
	);

endmodule

`default_nettype wire
